### hw/rtl/timer_queue_scheduler_top_defines.svh
// Assertion macros for the timer queue scheduler.
// The enclosing module must have clk and rst_n in scope.
`ifndef TIMER_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`define TIMER_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TQS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define TQS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define TQS_ASSERT_IMP(lbl, ante, cons)
`define TQS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/tqs_pkg.sv
package tqs_pkg;

    typedef logic [47:0] tick_t;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_POLL   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_ADDED     = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_FIRED     = 3'd3,
        KIND_POLL_DONE = 3'd4
    } kind_t;

    localparam logic REG_MIN_DELAY = 1'b0;
    localparam logic REG_IDLE_WAIT = 1'b1;

    localparam logic [15:0] MIN_DELAY_RST = 16'd1;
    localparam logic [15:0] IDLE_WAIT_RST = 16'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_ADD_OUT,
        ST_CAN_SCAN,
        ST_CAN_OUT,
        ST_SEL_SCAN,
        ST_FIRE,
        ST_DONE
    } st_t;

    typedef struct packed {
        logic [31:0] id;
        tick_t       deadline;
        tick_t       period;
        logic        rep;
        logic [15:0] tag;
    } slot_entry_t;

    typedef struct packed {
        op_t         op;
        tick_t       now;
        tick_t       deadline;
        tick_t       period;
        logic        rep;
        logic [15:0] tag;
        logic [31:0] cancel_id;
    } item_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [31:0] id;
        logic [15:0] tag;
        logic        earliest;
        logic [30:0] wait_ticks;
        logic        last;
    } result_t;

    function automatic tick_t sat_add(input tick_t a, input tick_t b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

endpackage

### hw/rtl/tqs_slot_mem.sv
module tqs_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  tqs_pkg::slot_entry_t wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output tqs_pkg::slot_entry_t rdata
);
    import tqs_pkg::*;

    slot_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/tqs_engine.sv
`include "timer_queue_scheduler_top_defines.svh"
module tqs_engine #(
    parameter int SLOTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  tqs_pkg::item_t   item,
    input  logic [15:0]      min_delay,
    input  logic [15:0]      idle_wait,
    input  logic             out_free,
    output tqs_pkg::result_t res
);
    import tqs_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW:0] CNT_END = (IW+1)'(SLOTS);

    st_t               state_reg, state_next;
    logic [IW:0]       cnt_reg, cnt_next;
    logic              rd_pend_reg;
    logic [IW-1:0]     rd_idx_reg;
    tick_t             now_reg, now_next;
    tick_t             dl_reg, dl_next;
    tick_t             per_reg, per_next;
    logic              rep_reg, rep_next;
    logic [15:0]       tag_reg, tag_next;
    logic [31:0]       id_reg, id_next;
    logic [31:0]       num_reg, num_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [SLOTS-1:0]  due_reg, due_next;
    logic              first_reg, first_next;
    logic              early_reg, early_next;
    logic              free_reg, free_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic              best_ok_reg, best_ok_next;
    slot_entry_t       best_reg, best_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    logic              min_any_reg, min_any_next;
    tick_t             min_dl_reg, min_dl_next;

    logic              rd_en;
    slot_entry_t       rdata;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    slot_entry_t       mem_wdata;
    logic              scanning;
    logic              scan_done;
    logic              ent_v;
    logic              cand;
    tick_t             diff;

    tqs_slot_mem #(.DEPTH(SLOTS), .AW(IW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (rd_en),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (rdata)
    );

    assign scanning = (state_reg == ST_ADD_SCAN) || (state_reg == ST_CAN_SCAN)
                   || (state_reg == ST_SEL_SCAN);
    assign rd_en     = scanning && (cnt_reg != CNT_END);
    assign scan_done = (cnt_reg == CNT_END) && !rd_pend_reg;
    assign ent_v     = valid_reg[rd_idx_reg];
    assign item_ready = (state_reg == ST_IDLE);
    assign diff      = min_dl_reg - now_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = rd_en ? cnt_reg + 1'b1 : cnt_reg;
        now_next      = now_reg;
        dl_next       = dl_reg;
        per_next      = per_reg;
        rep_next      = rep_reg;
        tag_next      = tag_reg;
        id_next       = id_reg;
        num_next      = num_reg;
        valid_next    = valid_reg;
        due_next      = due_reg;
        first_next    = first_reg;
        early_next    = early_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        best_ok_next  = best_ok_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        min_any_next  = min_any_reg;
        min_dl_next   = min_dl_reg;
        mem_we        = 1'b0;
        mem_waddr     = free_idx_reg;
        mem_wdata     = '{id: id_reg, deadline: dl_reg, period: per_reg,
                          rep: rep_reg, tag: tag_reg};
        cand          = 1'b0;
        res           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (item_valid)
                begin
                    now_next = item.now;
                    unique case (item.op)
                        OP_ADD:
                        begin
                            id_next    = num_reg;
                            num_next   = num_reg + 32'd1;
                            dl_next    = (item.deadline <= item.now)
                                       ? sat_add(item.now, {32'd0, min_delay})
                                       : item.deadline;
                            per_next   = (item.rep && item.period == '0)
                                       ? {32'd0, min_delay} : item.period;
                            rep_next   = item.rep;
                            tag_next   = item.tag;
                            early_next = 1'b1;
                            free_next  = 1'b0;
                            state_next = ST_ADD_SCAN;
                        end
                        OP_CANCEL:
                        begin
                            id_next    = item.cancel_id;
                            state_next = ST_CAN_SCAN;
                        end
                        OP_POLL:
                        begin
                            first_next   = 1'b1;
                            best_ok_next = 1'b0;
                            min_any_next = 1'b0;
                            state_next   = ST_SEL_SCAN;
                        end
                        OP_NONE:
                        begin
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD_SCAN:
            begin
                if (rd_pend_reg)
                begin
                    if (ent_v && !(dl_reg < rdata.deadline))
                    begin
                        early_next = 1'b0;
                    end
                    if (!ent_v && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                end
                if (scan_done)
                begin
                    state_next = ST_ADD_OUT;
                end
            end
            ST_ADD_OUT:
            begin
                if (out_free)
                begin
                    res.valid = 1'b1;
                    res.id    = id_reg;
                    res.last  = 1'b1;
                    if (free_reg)
                    begin
                        res.kind     = KIND_ADDED;
                        res.earliest = early_reg;
                        mem_we       = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        res.kind = KIND_FULL;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_CAN_SCAN:
            begin
                if (rd_pend_reg && ent_v && rdata.id == id_reg)
                begin
                    valid_next[rd_idx_reg] = 1'b0;
                end
                if (scan_done)
                begin
                    state_next = ST_CAN_OUT;
                end
            end
            ST_CAN_OUT:
            begin
                if (out_free)
                begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_CANCELLED;
                    res.id     = id_reg;
                    res.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SEL_SCAN:
            begin
                if (rd_pend_reg)
                begin
                    // first pass latches the due set as of poll start
                    cand = first_reg ? (ent_v && rdata.deadline <= now_reg)
                                     : due_reg[rd_idx_reg];
                    if (first_reg)
                    begin
                        due_next[rd_idx_reg] = cand;
                    end
                    if (cand && (!best_ok_reg || rdata.deadline < best_reg.deadline
                        || (rdata.deadline == best_reg.deadline
                            && rdata.id < best_reg.id)))
                    begin
                        best_ok_next  = 1'b1;
                        best_next     = rdata;
                        best_idx_next = rd_idx_reg;
                    end
                    if (ent_v && (!min_any_reg || rdata.deadline < min_dl_reg))
                    begin
                        min_any_next = 1'b1;
                        min_dl_next  = rdata.deadline;
                    end
                end
                if (scan_done)
                begin
                    state_next = best_ok_reg ? ST_FIRE : ST_DONE;
                end
            end
            ST_FIRE:
            begin
                if (out_free)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_FIRED;
                    res.id    = best_reg.id;
                    res.tag   = best_reg.tag;
                    due_next[best_idx_reg] = 1'b0;
                    if (best_reg.rep)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = best_idx_reg;
                        mem_wdata = best_reg;
                        mem_wdata.deadline = sat_add(now_reg, best_reg.period);
                    end
                    else
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                    end
                    first_next   = 1'b0;
                    best_ok_next = 1'b0;
                    min_any_next = 1'b0;
                    cnt_next     = '0;
                    state_next   = ST_SEL_SCAN;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_POLL_DONE;
                    res.last  = 1'b1;
                    if (!min_any_reg)
                    begin
                        res.wait_ticks = {15'd0, idle_wait};
                    end
                    else if (min_dl_reg <= now_reg)
                    begin
                        res.wait_ticks = '0;
                    end
                    else if (|diff[47:31])
                    begin
                        res.wait_ticks = '1;
                    end
                    else
                    begin
                        res.wait_ticks = diff[30:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            num_reg     <= '0;
            valid_reg   <= '0;
            due_reg     <= '0;
            first_reg   <= 1'b0;
            early_reg   <= 1'b0;
            free_reg    <= 1'b0;
            best_ok_reg <= 1'b0;
            min_any_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_en;
            num_reg     <= num_next;
            valid_reg   <= valid_next;
            due_reg     <= due_next;
            first_reg   <= first_next;
            early_reg   <= early_next;
            free_reg    <= free_next;
            best_ok_reg <= best_ok_next;
            min_any_reg <= min_any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= cnt_reg[IW-1:0];
        now_reg      <= now_next;
        dl_reg       <= dl_next;
        per_reg      <= per_next;
        rep_reg      <= rep_next;
        tag_reg      <= tag_next;
        id_reg       <= id_next;
        free_idx_reg <= free_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        min_dl_reg   <= min_dl_next;
    end

    `TQS_ASSERT_IMP(a_emit_when_free, res.valid, out_free)
    `TQS_ASSERT_IMP(a_scan_bound, 1'b1, cnt_reg <= CNT_END)
    `TQS_ASSERT_NXT(a_written_slot_valid, mem_we, valid_reg[$past(mem_waddr)])
    `TQS_ASSERT_NXT(a_accept_leaves_idle, item_valid && item_ready && item.op != OP_NONE,
                    state_reg != ST_IDLE)

endmodule

### hw/rtl/timer_queue_scheduler_top.sv
// Timer queue scheduler: a table of TIMER_SLOTS one-shot or repeating timers.
// Requests enter on s_axis (tuser = op: add, cancel, poll); results leave on
// m_axis (tuser = kind), tlast marking the final result of each request.
// Settings come in on the cfg channel (index 0 min_delay, 1 idle_wait),
// to be written only while the block is idle; the block itself does not
// enforce this. cfg_ready is always high.
// Every add and cancel sweeps the slot memory once. A poll that fires F
// timers sweeps it F+1 times: one sweep and one result per fired timer, plus
// a closing sweep that also finds the next deadline and gives the last result.
// The engine is back in idle, ready for the next request, once its last
// result is registered. The slot memory has a single read port; one request
// is in flight at a time.
// Reset clears all slot valid bits, the id counter and the output valid flag,
// and loads min_delay 1 and idle_wait 100; slot contents are not cleared.
// A stalled receiver holds the result in the output register; the engine
// waits with its next result until that register is free, so nothing is lost.
module timer_queue_scheduler_top #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // now_time[47:0], first_deadline[95:48], period[143:96], repeating[144],
    // owner_tag[160:145], cancel_id[192:161], zero fill up to 199
    input  logic [199:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // id[31:0], fired_tag[47:32], new_earliest[48], wait_ticks[79:49]
    output logic [79:0]  m_axis_tdata,
    // kind[2:0]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);
    import tqs_pkg::*;

    logic [15:0] min_delay_reg;
    logic [15:0] idle_wait_reg;
    item_t       item;
    result_t     res;
    logic        out_free;
    logic        m_valid_reg;
    result_t     m_res_reg;

    // unpack the request
    assign item.op        = op_t'(s_axis_tuser);
    assign item.now       = s_axis_tdata[47:0];
    assign item.deadline  = s_axis_tdata[95:48];
    assign item.period    = s_axis_tdata[143:96];
    assign item.rep       = s_axis_tdata[144];
    assign item.tag       = s_axis_tdata[160:145];
    assign item.cancel_id = s_axis_tdata[192:161];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delay_reg <= MIN_DELAY_RST;
            idle_wait_reg <= IDLE_WAIT_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_MIN_DELAY)
            begin
                min_delay_reg <= cfg_data;
            end
            if (cfg_index == REG_IDLE_WAIT)
            begin
                idle_wait_reg <= cfg_data;
            end
        end
    end

    tqs_engine #(.SLOTS(TIMER_SLOTS)) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_axis_tvalid),
        .item_ready (s_axis_tready),
        .item       (item),
        .min_delay  (min_delay_reg),
        .idle_wait  (idle_wait_reg),
        .out_free   (out_free),
        .res        (res)
    );

    // output register: free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res.valid)
        begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_res_reg.wait_ticks, m_res_reg.earliest,
                            m_res_reg.tag, m_res_reg.id};
    assign m_axis_tuser  = m_res_reg.kind;
    assign m_axis_tlast  = m_res_reg.last;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tqs_pkg::*;

    localparam int SLOTS = 16;
    localparam int RAND_REQUESTS = 300;
    localparam int CYCLE_LIMIT = 900000;
    // Quiet time allowed once nothing is outstanding: a full poll of all
    // slots, plus margin.
    localparam int DRAIN_CYCLES = 17 * (SLOTS + 2) + 50;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [15:0]  cfg_data;

    // One result as it leaves the block.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] id;
        logic [15:0] tag;
        logic        earliest;
        logic [30:0] wait_ticks;
        logic        last;
    } outcome_t;

    // Mirror of the timer table and settings.
    logic        tbl_valid [SLOTS];
    logic [31:0] tbl_id    [SLOTS];
    tick_t       tbl_dl    [SLOTS];
    tick_t       tbl_per   [SLOTS];
    logic        tbl_rep   [SLOTS];
    logic [15:0] tbl_tag   [SLOTS];
    logic [31:0] id_counter;
    logic [15:0] min_delay_q;
    logic [15:0] idle_wait_q;

    item_t    pending_requests [$];
    outcome_t expected_outcomes [$];

    int     error_count;
    int     cycle_count;
    int     send_gap;
    int     recv_gap;
    int     hold_off;
    logic   hold_req;
    int     queued_adds;

    timer_queue_scheduler_top #(.TIMER_SLOTS(SLOTS)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void queue_request(input item_t r);
        pending_requests.insert(pending_requests.size(), r);
    endfunction

    function automatic void expect_outcome(input outcome_t o);
        expected_outcomes.insert(expected_outcomes.size(), o);
    endfunction

    function automatic tick_t tick_sum(tick_t a, tick_t b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[48])
            return '1;
        return s[47:0];
    endfunction

    function automatic outcome_t make_outcome(kind_t k, logic [31:0] id, logic [15:0] tag,
                                              logic early, logic [30:0] w, logic lst);
        outcome_t o;
        o.kind = k;
        o.id = id;
        o.tag = tag;
        o.earliest = early;
        o.wait_ticks = w;
        o.last = lst;
        return o;
    endfunction

    // Advance the timer table by one request and queue what it should produce.
    task automatic predict_timer_request(input item_t req);
        logic [31:0] id;
        tick_t       dl;
        tick_t       per;
        int          free_slot;
        logic        early;
        logic        due [SLOTS];
        int          b;
        logic        any;
        tick_t       best;
        tick_t       w;
        begin
            case (req.op)
                OP_ADD:
                begin
                    id = id_counter;
                    id_counter = id_counter + 32'd1;
                    dl = req.deadline;
                    per = req.period;
                    if (req.rep && per == 0)
                        per = {32'd0, min_delay_q};
                    if (dl <= req.now)
                        dl = tick_sum(req.now, {32'd0, min_delay_q});
                    free_slot = -1;
                    early = 1'b1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (tbl_valid[i])
                        begin
                            if (!(dl < tbl_dl[i]))
                                early = 1'b0;
                        end
                        else if (free_slot < 0)
                            free_slot = i;
                    end
                    if (free_slot < 0)
                        expect_outcome(make_outcome(KIND_FULL, id, 0, 0, 0, 1));
                    else
                    begin
                        tbl_valid[free_slot] = 1'b1;
                        tbl_id[free_slot] = id;
                        tbl_dl[free_slot] = dl;
                        tbl_per[free_slot] = per;
                        tbl_rep[free_slot] = req.rep;
                        tbl_tag[free_slot] = req.tag;
                        expect_outcome(make_outcome(KIND_ADDED, id, 0, early, 0, 1));
                    end
                end
                OP_CANCEL:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (tbl_valid[i] && tbl_id[i] == req.cancel_id)
                            tbl_valid[i] = 1'b0;
                    expect_outcome(make_outcome(KIND_CANCELLED, req.cancel_id, 0, 0, 0, 1));
                end
                OP_POLL:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        due[i] = tbl_valid[i] && tbl_dl[i] <= req.now;
                    forever
                    begin
                        b = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (due[i] && (b < 0 || tbl_dl[i] < tbl_dl[b] ||
                                (tbl_dl[i] == tbl_dl[b] && tbl_id[i] < tbl_id[b])))
                                b = i;
                        if (b < 0)
                            break;
                        due[b] = 1'b0;
                        expect_outcome(make_outcome(KIND_FIRED, tbl_id[b], tbl_tag[b], 0, 0, 0));
                        if (tbl_rep[b])
                            tbl_dl[b] = tick_sum(req.now, tbl_per[b]);
                        else
                            tbl_valid[b] = 1'b0;
                    end
                    any = 1'b0;
                    best = '0;
                    for (int i = 0; i < SLOTS; i++)
                        if (tbl_valid[i] && (!any || tbl_dl[i] < best))
                        begin
                            best = tbl_dl[i];
                            any = 1'b1;
                        end
                    if (!any)
                        w = {32'd0, idle_wait_q};
                    else if (best <= req.now)
                        w = '0;
                    else
                        w = best - req.now;
                    if (w > 48'h7FFF_FFFF)
                        w = 48'h7FFF_FFFF;
                    expect_outcome(make_outcome(KIND_POLL_DONE, 0, 0, 0, w[30:0], 1));
                end
                default: ;
            endcase
        end
    endtask

    task automatic report_mismatch(input string what);
        begin
            $display("ERROR @%0t: %s", $time, what);
            error_count++;
        end
    endtask

    // Request driver: hold each request until accepted, then a random gap before the next.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= OP_NONE;
            send_gap      <= 0;
        end
        else if (s_axis_tvalid && !s_axis_tready)
            ;
        else if (send_gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_requests.size() > 0)
        begin
            item_t r;
            r = pending_requests.pop_front();
            predict_timer_request(r);
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= r.op;
            s_axis_tdata  <= {7'd0, r.cancel_id, r.tag, r.rep, r.period, r.deadline, r.now};
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // Long hold-off on the result side, counted here on its own.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_off <= 0;
        else if (hold_req && hold_off == 0)
            hold_off <= 400;
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // Result monitor: random stalls, compare against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                outcome_t got;
                outcome_t exp_o;
                got = make_outcome(kind_t'(m_axis_tuser), m_axis_tdata[31:0],
                                   m_axis_tdata[47:32], m_axis_tdata[48],
                                   m_axis_tdata[79:49], m_axis_tlast);
                if (expected_outcomes.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d", got.kind));
                else
                begin
                    exp_o = expected_outcomes.pop_front();
                    if (got.kind !== exp_o.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", got.kind, exp_o.kind));
                    if (got.id !== exp_o.id)
                        report_mismatch($sformatf("id %0h, want %0h", got.id, exp_o.id));
                    if (got.tag !== exp_o.tag)
                        report_mismatch($sformatf("tag %0h, want %0h", got.tag, exp_o.tag));
                    if (got.earliest !== exp_o.earliest)
                        report_mismatch($sformatf("earliest %0b, want %0b",
                                                  got.earliest, exp_o.earliest));
                    if (got.wait_ticks !== exp_o.wait_ticks)
                        report_mismatch($sformatf("wait %0d, want %0d",
                                                  got.wait_ticks, exp_o.wait_ticks));
                    if (got.last !== exp_o.last)
                        report_mismatch($sformatf("last %0b, want %0b", got.last, exp_o.last));
                end
            end
            if (hold_off > 0)
                m_axis_tready <= 1'b0;
            else if (recv_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic item_t make_request(op_t op, tick_t now, tick_t dl, tick_t per,
                                           logic rep, logic [15:0] tag, logic [31:0] cid);
        item_t r;
        r.op = op;
        r.now = now;
        r.deadline = dl;
        r.period = per;
        r.rep = rep;
        r.tag = tag;
        r.cancel_id = cid;
        return r;
    endfunction

    function automatic tick_t rand_tick();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Approximate next id, counted at acceptance rather than queue time.
    function automatic logic [31:0] id_guess();
        return 32'(queued_adds);
    endfunction

    always @(posedge clk)
        if (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_ADD)
            queued_adds <= queued_adds + 1;

    // Wait for all results, then the worst-case engine latency.
    task automatic wait_drained();
        begin
            while (pending_requests.size() > 0 || s_axis_tvalid || expected_outcomes.size() > 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_setting(input logic idx, input logic [15:0] val);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            if (idx == REG_MIN_DELAY)
                min_delay_q = val;
            else
                idle_wait_q = val;
        end
    endtask

    // Mostly realistic traffic around a moving clock, with cancels of mostly recent ids.
    task automatic queue_random_phase(input int count, input tick_t start);
        tick_t   clk_now;
        int      pick;
        begin
            clk_now = start;
            for (int n = 0; n < count; n++)
            begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                    clk_now = rand_tick();
                else
                    clk_now = clk_now + 48'($urandom_range(0, 300));
                if (pick < 45)
                    queue_request(make_request(OP_ADD, clk_now,
                        ($urandom_range(0, 7) == 0) ? rand_tick()
                            : clk_now + 48'($urandom_range(0, 600)) - 48'd100,
                        ($urandom_range(0, 7) == 0) ? rand_tick()
                            : 48'($urandom_range(0, 400)),
                        1'($urandom_range(0, 1)), 16'($urandom()), 32'd0));
                else if (pick < 60)
                    queue_request(make_request(OP_CANCEL, clk_now, 0, 0, 0, 0,
                        ($urandom_range(0, 4) == 0) ? $urandom()
                            : id_guess() - 32'($urandom_range(0, 20))));
                else if (pick < 97)
                    queue_request(make_request(OP_POLL, clk_now, 0, 0, 0, 0, 0));
                else
                    queue_request(make_request(OP_NONE, rand_tick(), rand_tick(),
                        rand_tick(), 1'($urandom_range(0, 1)), 16'($urandom()), $urandom()));
            end
        end
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        queued_adds = 0;
        hold_req = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_DELAY;
        cfg_data = '0;
        id_counter = '0;
        min_delay_q = MIN_DELAY_RST;
        idle_wait_q = IDLE_WAIT_RST;
        for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle poll, past deadline, zero-period repeater, ties,
        // extremes, saturation, unknown cancel, unused op, table full.
        queue_request(make_request(OP_POLL, 0, 0, 0, 0, 0, 0));
        queue_request(make_request(OP_ADD, 1000, 500, 0, 1, 16'hFFFF, 0));
        queue_request(make_request(OP_ADD, 1000, 2000, 0, 0, 16'h0001, 0));
        queue_request(make_request(OP_ADD, 1000, 2000, 7, 1, 16'h1234, 0));
        queue_request(make_request(OP_ADD, 48'hFFFF_FFFF_FFFF,
            48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, 16'hA5A5, 0));
        queue_request(make_request(OP_CANCEL, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        queue_request(make_request(OP_NONE, 48'hFFFF_FFFF_FFFF,
            48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, 16'hFFFF, 32'hFFFF_FFFF));
        queue_request(make_request(OP_POLL, 2000, 0, 0, 0, 0, 0));
        queue_request(make_request(OP_POLL, 2000, 0, 0, 0, 0, 0));
        queue_request(make_request(OP_CANCEL, 0, 0, 0, 0, 0, 3));
        queue_request(make_request(OP_POLL, 48'hFFFF_FFFF_FFFE, 0, 0, 0, 0, 0));
        for (int i = 0; i < 16; i++)
            queue_request(make_request(OP_ADD, 5, 48'h0000_F000_0000 + 48'(i % 3),
                48'(i), i[0], 16'(i), 0));
        wait_drained();

        // Extreme settings, then fire everything with min_delay zero.
        write_setting(REG_MIN_DELAY, 16'd0);
        write_setting(REG_IDLE_WAIT, 16'hFFFF);
        queue_request(make_request(OP_POLL, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0));
        queue_request(make_request(OP_ADD, 10, 3, 0, 1, 16'h0F0F, 0));
        queue_request(make_request(OP_POLL, 10, 0, 0, 0, 0, 0));
        for (int i = 0; i < 20; i++)
            queue_request(make_request(OP_CANCEL, 0, 0, 0, 0, 0, 32'(i)));
        queue_request(make_request(OP_POLL, 10, 0, 0, 0, 0, 0));
        wait_drained();

        write_setting(REG_MIN_DELAY, 16'hFFFF);
        write_setting(REG_IDLE_WAIT, 16'd0);
        queue_random_phase(100, 48'd1000);
        // Block the result side while requests keep coming.
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        wait_drained();

        write_setting(REG_MIN_DELAY, 16'd1);
        write_setting(REG_IDLE_WAIT, 16'd100);
        queue_random_phase(100, 48'd0);
        wait_drained();

        write_setting(REG_MIN_DELAY, 16'($urandom_range(1, 200)));
        write_setting(REG_IDLE_WAIT, 16'($urandom()));
        queue_random_phase(RAND_REQUESTS - 250, 48'h7FFF_0000_0000);
        wait_drained();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
